@@ sv/cpvf_pkg.sv @@
package cpvf_pkg;

    localparam int CPVF_FRAC_BITS = 16;
    localparam int MUL_B_W        = 30;
    localparam int EST_W          = 32;
    localparam int NUM_AXES       = 3;

    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [1:0] REG_POSITION_BLEND = 2'd0;
    localparam logic [1:0] REG_VELOCITY_BLEND = 2'd1;
    localparam logic [1:0] REG_VELOCITY_GAIN  = 2'd2;
    localparam logic [1:0] REG_ACCEL_DEADBAND = 2'd3;

    localparam logic [16:0] POSITION_BLEND_RST = 17'd13107;
    localparam logic [16:0] VELOCITY_BLEND_RST = 17'd52429;
    localparam logic [23:0] VELOCITY_GAIN_RST  = 24'd65536;
    localparam logic [30:0] ACCEL_DEADBAND_RST = 31'd2621;

    typedef struct packed {
        logic [16:0] position_blend;
        logic [16:0] velocity_blend;
        logic [23:0] velocity_gain;
        logic [30:0] accel_deadband;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEADBAND,
        ST_MUL_DT,
        ST_ROUND_DT,
        ST_MUL_G,
        ST_ROUND_G,
        ST_MUL_OLD,
        ST_MUL_MEAS,
        ST_MUL_GAIN,
        ST_ACC_GAIN,
        ST_WRITE,
        ST_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        OPND_DT,
        OPND_G,
        OPND_OLD,
        OPND_MEAS,
        OPND_GAIN
    } opnd_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic    capture;
        logic    calc_db;
        logic    mul_en;
        opnd_t   opnd;
        acc_op_t acc_op;
        logic    integ_load;
        logic    write_est;
        logic    axis_inc;
    } cmd_t;

    typedef struct packed {
        logic is_vel;
        logic axis_last;
        logic skip;
    } sts_t;

endpackage

@@ sv/cpvf_regs.sv @@
module cpvf_regs
    import cpvf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.position_blend <= POSITION_BLEND_RST;
            cfg_reg.velocity_blend <= VELOCITY_BLEND_RST;
            cfg_reg.velocity_gain  <= VELOCITY_GAIN_RST;
            cfg_reg.accel_deadband <= ACCEL_DEADBAND_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_POSITION_BLEND: cfg_reg.position_blend <= pwdata[16:0];
                REG_VELOCITY_BLEND: cfg_reg.velocity_blend <= pwdata[16:0];
                REG_VELOCITY_GAIN:  cfg_reg.velocity_gain  <= pwdata[23:0];
                REG_ACCEL_DEADBAND: cfg_reg.accel_deadband <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_POSITION_BLEND: prdata = 32'(cfg_reg.position_blend);
            REG_VELOCITY_BLEND: prdata = 32'(cfg_reg.velocity_blend);
            REG_VELOCITY_GAIN:  prdata = 32'(cfg_reg.velocity_gain);
            REG_ACCEL_DEADBAND: prdata = 32'(cfg_reg.accel_deadband);
            default:            prdata = '0;
        endcase
    end

endmodule

@@ sv/cpvf_datapath.sv @@
module cpvf_datapath
    import cpvf_pkg::*;
#(
    parameter int FRAC_BITS = CPVF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  cfg_t                      cfg,
    input  logic [239:0]              in_data,
    input  logic [2:0]                in_user,
    output logic [2*NUM_AXES*EST_W-1:0] est_data
);

    localparam logic [MUL_B_W-1:0] ONE_Q = MUL_B_W'(64'd1 << FRAC_BITS);
    localparam longint unsigned G_Q_L =
        (64'd981 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [MUL_B_W-1:0] G_Q = MUL_B_W'(G_Q_L);
    localparam logic signed [63:0] HALF_Q  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    function automatic logic signed [EST_W-1:0] round_sat(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = (x + HALF_Q) >>> FRAC_BITS;
        if (r > S32_MAX) begin
            return S32_MAX[EST_W-1:0];
        end else if (r < S32_MIN) begin
            return S32_MIN[EST_W-1:0];
        end
        return r[EST_W-1:0];
    endfunction

    logic signed [EST_W-1:0] est_pos_reg [NUM_AXES];
    logic signed [EST_W-1:0] est_vel_reg [NUM_AXES];
    logic signed [EST_W-1:0] latched_reg [NUM_AXES];
    logic signed [EST_W-1:0] meas_pos_reg [NUM_AXES];
    logic signed [EST_W-1:0] accel_reg;
    logic [15:0]             dt_reg;
    logic                    is_vel_reg;
    logic [1:0]              axis_reg;
    logic signed [EST_W-1:0] db_reg;
    logic signed [EST_W-1:0] integ_reg;
    logic signed [62:0]      prod_reg;
    logic signed [63:0]      acc_reg;

    logic signed [EST_W-1:0] op_a;
    logic [MUL_B_W-1:0]      op_b;
    logic [MUL_B_W-1:0]      w_pos;
    logic [MUL_B_W-1:0]      w_vel;
    logic [MUL_B_W-1:0]      w_sel;
    logic signed [63:0]      prod_ext;
    logic signed [32:0]      acc_w;
    logic signed [32:0]      th_w;
    logic signed [32:0]      db_next;

    assign sts.is_vel    = is_vel_reg;
    assign sts.axis_last = (axis_reg == AXIS_Z);
    assign sts.skip      = is_vel_reg && (axis_reg == AXIS_NONE);

    assign w_pos = (MUL_B_W'(cfg.position_blend) > ONE_Q) ? ONE_Q
                                                            : MUL_B_W'(cfg.position_blend);
    assign w_vel = (MUL_B_W'(cfg.velocity_blend) > ONE_Q) ? ONE_Q
                                                            : MUL_B_W'(cfg.velocity_blend);
    assign w_sel = is_vel_reg ? w_vel : w_pos;

    always_comb begin
        unique case (cmd.opnd)
            OPND_DT: begin
                op_a = is_vel_reg ? db_reg : est_vel_reg[axis_reg];
                op_b = MUL_B_W'(dt_reg);
            end
            OPND_G: begin
                op_a = integ_reg;
                op_b = G_Q;
            end
            OPND_OLD: begin
                op_a = is_vel_reg ? est_vel_reg[axis_reg] : est_pos_reg[axis_reg];
                op_b = w_sel;
            end
            OPND_MEAS: begin
                op_a = is_vel_reg ? latched_reg[axis_reg] : meas_pos_reg[axis_reg];
                op_b = ONE_Q - w_sel;
            end
            OPND_GAIN: begin
                op_a = integ_reg;
                op_b = MUL_B_W'(cfg.velocity_gain);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_ext = 64'(prod_reg);

    // deadband: zero inside the threshold, else shrink toward zero
    assign acc_w = 33'(accel_reg);
    assign th_w  = $signed({2'b00, cfg.accel_deadband});

    always_comb begin
        priority if (acc_w < th_w && acc_w > -th_w) begin
            db_next = '0;
        end else if (acc_w > 33'sd0) begin
            db_next = acc_w - th_w;
        end else if (acc_w < 33'sd0) begin
            db_next = acc_w + th_w;
        end else begin
            db_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_vel_reg <= 1'b0;
            axis_reg   <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                est_pos_reg[i] <= '0;
                est_vel_reg[i] <= '0;
                latched_reg[i] <= '0;
            end
        end else begin
            if (cmd.capture) begin
                is_vel_reg <= in_user[0];
                axis_reg   <= in_user[0] ? in_user[2:1] : 2'd0;
                if (!in_user[0]) begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        latched_reg[i] <= in_data[(NUM_AXES+i)*EST_W +: EST_W];
                    end
                end
            end else if (cmd.axis_inc) begin
                axis_reg <= axis_reg + 2'd1;
            end
            if (cmd.write_est) begin
                if (is_vel_reg) begin
                    est_vel_reg[axis_reg] <= round_sat(acc_reg);
                end else begin
                    est_pos_reg[axis_reg] <= round_sat(acc_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                meas_pos_reg[i] <= in_data[i*EST_W +: EST_W];
            end
            accel_reg <= in_data[223:192];
            dt_reg    <= in_data[239:224];
        end
        if (cmd.calc_db) begin
            db_reg <= db_next[EST_W-1:0];
        end
        if (cmd.mul_en) begin
            prod_reg <= op_a * $signed({1'b0, op_b});
        end
        if (cmd.integ_load) begin
            integ_reg <= round_sat(prod_ext);
        end
        unique case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:  ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            est_data[i*EST_W +: EST_W]            = est_pos_reg[i];
            est_data[(NUM_AXES+i)*EST_W +: EST_W] = est_vel_reg[i];
        end
    end

endmodule

@@ sv/cpvf_ctrl.sv @@
module cpvf_ctrl
    import cpvf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd.capture    = 1'b0;
        cmd.calc_db    = 1'b0;
        cmd.mul_en     = 1'b0;
        cmd.opnd       = OPND_DT;
        cmd.acc_op     = ACC_HOLD;
        cmd.integ_load = 1'b0;
        cmd.write_est  = 1'b0;
        cmd.axis_inc   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DEADBAND;
                end
            end
            ST_DEADBAND: begin
                cmd.calc_db = 1'b1;
                state_next  = sts.skip ? ST_OUTPUT : ST_MUL_DT;
            end
            ST_MUL_DT: begin
                cmd.mul_en = 1'b1;
                cmd.opnd   = OPND_DT;
                state_next = ST_ROUND_DT;
            end
            ST_ROUND_DT: begin
                cmd.integ_load = 1'b1;
                state_next     = sts.is_vel ? ST_MUL_G : ST_MUL_OLD;
            end
            ST_MUL_G: begin
                cmd.mul_en = 1'b1;
                cmd.opnd   = OPND_G;
                state_next = ST_ROUND_G;
            end
            ST_ROUND_G: begin
                cmd.integ_load = 1'b1;
                state_next     = ST_MUL_OLD;
            end
            ST_MUL_OLD: begin
                cmd.mul_en = 1'b1;
                cmd.opnd   = OPND_OLD;
                state_next = ST_MUL_MEAS;
            end
            ST_MUL_MEAS: begin
                cmd.acc_op = ACC_LOAD;
                cmd.mul_en = 1'b1;
                cmd.opnd   = OPND_MEAS;
                state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: begin
                cmd.acc_op = ACC_ADD;
                cmd.mul_en = 1'b1;
                cmd.opnd   = OPND_GAIN;
                state_next = ST_ACC_GAIN;
            end
            ST_ACC_GAIN: begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.write_est = 1'b1;
                if (!sts.is_vel && !sts.axis_last) begin
                    cmd.axis_inc = 1'b1;
                    state_next   = ST_MUL_DT;
                end else begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_write_on_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.write_est && sts.skip))
        else $error("estimate written for an out-of-range axis");

    a_output_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transaction");

    a_capture_then_deadband: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_DEADBAND))
        else $error("capture not followed by deadband step");

    a_axis_inc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.axis_inc |-> (!sts.axis_last && !sts.is_vel))
        else $error("axis stepped past the last axis");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd.capture)
        else $error("item captured while busy");

endmodule

@@ sv/complementary_position_velocity_filter.sv @@
// Three-axis complementary position/velocity filter in signed fixed point
// (FRAC_BITS fraction bits, 16 by default). A position transaction blends
// each axis position with its measurement and adds gain*vel*dt, and latches
// the measured velocities; a velocity transaction updates one axis velocity
// from an acceleration in g through a deadband, dt, 9.81 and the gain. Every
// transaction returns one result with all six estimates. All products go
// through one shared 32x30 multiplier, at most one product per cycle, each
// followed by a register. After capture and deadband, per axis a position
// transaction rounds vel*dt and sums the old, measured and gain products;
// a velocity one also rounds a 9.81 product, and one with axis 3 changes
// no estimate. A new transaction is taken once the previous result is taken.
module complementary_position_velocity_filter
    import cpvf_pkg::*;
#(
    parameter int FRAC_BITS = CPVF_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // meas_x, meas_y, meas_z, meas_vx, meas_vy, meas_vz, accel, time_step
    input  logic [239:0] s_axis_tdata,
    // req_type, axis
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic [191:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    cpvf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpvf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cpvf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .est_data (m_axis_tdata)
    );

endmodule
